@@ rtl/cst_pkg.sv @@
// Package for the connection slot table: sizes, operation and status codes,
// and the command and status bundles between controller and datapath.
// No dependencies.
package cst_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int SLOT_W      = 11;
    localparam int SOCK_W      = 31;
    localparam int PORT_W      = 16;
    localparam int MODE_W      = 2;
    localparam int STAT_W      = 2;

    localparam logic [SLOT_W-1:0] MAX_SLOT = SLOT_W'(MAX_ENTRIES);

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADSLOT  = 2'd3;

    typedef struct packed {
        logic clr;        // one step of the valid-bit clearing sweep
        logic load;       // capture the input item
        logic ins_rd;     // read top of the free stack
        logic ins_wr;     // write the new entry
        logic ins_link;   // link the new entry behind the old tail
        logic rm_rd;      // read the addressed slot
        logic rm_exec;    // unlink and free the addressed slot
        logic sr_rd;      // read the slot under the search cursor
        logic sr_step;    // advance the search cursor
        logic res_full;
        logic res_bad;
        logic res_nf;
        logic res_rd;
        logic res_found;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic             clr_last;
        logic [MODE_W-1:0] mode;
        logic             full;
        logic             slot_bad;
        logic             valid_q;
        logic             match;
        logic             cur_end;
        logic             out_free;
    } t_sts;

    // 1-based slot number to 0-based memory index.
    function automatic logic [IDX_W-1:0] idx_of(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] t;
        t = s - 1'b1;
        return t[IDX_W-1:0];
    endfunction

endpackage

@@ rtl/connection_slot_table.sv @@
// Top level of the connection slot table: controller plus datapath.
// Depends on cst_pkg, cst_ctrl and cst_dp.
//
// Holds up to 1024 connections (socket id, port) in 1-based slots, hands out
// freed slot numbers last-freed-first, and keeps insertion order for search.
// One item at a time; a search walks entries in insertion order, reads the
// link memory once per step, and visits at most 1024 entries. Once the
// output register is free the result moves into it, and the next item is
// taken while that result waits. After reset the block sweeps its 1024 valid
// bits, one per cycle, and takes no item until the sweep ends.
module connection_slot_table import cst_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [SOCK_W-1:0] i_sock_id,
    input  logic [PORT_W-1:0] i_port_num,
    input  logic              i_by_port,
    input  logic [SLOT_W-1:0] i_slot_in,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [STAT_W-1:0] o_status,
    output logic [SLOT_W-1:0] o_slot_out,
    output logic [SOCK_W-1:0] o_sock_out,
    output logic [PORT_W-1:0] o_port_out,
    output logic [SLOT_W-1:0] o_entry_count
);

    t_cmd cmd;
    t_sts sts;

    cst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .i_sts   (sts),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    cst_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_mode        (i_mode),
        .i_sock_id     (i_sock_id),
        .i_port_num    (i_port_num),
        .i_by_port     (i_by_port),
        .i_slot_in     (i_slot_in),
        .i_out_stall   (i_stall),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_slot_out    (o_slot_out),
        .o_sock_out    (o_sock_out),
        .o_port_out    (o_port_out),
        .o_entry_count (o_entry_count)
    );

endmodule

@@ rtl/cst_ctrl.sv @@
// Controller of the connection slot table: sequences the clearing sweep and
// every operation. Depends on cst_pkg.
module cst_ctrl import cst_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [MODE_W-1:0] i_mode,
    input  t_sts              i_sts,
    output logic              o_stall,
    output t_cmd              o_cmd
);

    typedef enum logic [9:0] {
        S_CLR  = 10'b0000000001,
        S_IDLE = 10'b0000000010,
        S_INS0 = 10'b0000000100,
        S_INS1 = 10'b0000001000,
        S_INS2 = 10'b0000010000,
        S_RD0  = 10'b0000100000,
        S_RD1  = 10'b0001000000,
        S_SR0  = 10'b0010000000,
        S_SR1  = 10'b0100000000,
        S_DONE = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_mode)
                        MODE_INSERT: n_state = S_INS0;
                        MODE_SEARCH: n_state = S_SR0;
                        default:     n_state = S_RD0;
                    endcase
                end
            end
            S_INS0: begin
                if (i_sts.full) begin
                    o_cmd.res_full = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.ins_rd = 1'b1;
                    n_state = S_INS1;
                end
            end
            S_INS1: begin
                o_cmd.ins_wr = 1'b1;
                n_state = S_INS2;
            end
            S_INS2: begin
                o_cmd.ins_link = 1'b1;
                n_state = S_DONE;
            end
            S_RD0: begin
                if (i_sts.slot_bad) begin
                    o_cmd.res_bad = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.rm_rd = 1'b1;
                    n_state = S_RD1;
                end
            end
            S_RD1: begin
                if (!i_sts.valid_q) begin
                    o_cmd.res_bad = 1'b1;
                end else if (i_sts.mode == MODE_READ) begin
                    o_cmd.res_rd = 1'b1;
                end else begin
                    o_cmd.rm_exec = 1'b1;
                end
                n_state = S_DONE;
            end
            S_SR0: begin
                if (i_sts.cur_end) begin
                    o_cmd.res_nf = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.sr_rd = 1'b1;
                    n_state = S_SR1;
                end
            end
            S_SR1: begin
                if (!i_sts.valid_q) begin
                    o_cmd.res_nf = 1'b1;
                    n_state = S_DONE;
                end else if (i_sts.match) begin
                    o_cmd.res_found = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.sr_step = 1'b1;
                    n_state = S_SR0;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

    // A result is only produced for an item that was taken.
    a_done_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> ($past(r_state) != S_IDLE && $past(r_state) != S_CLR))
        else $error("result stage entered without an operation");

    // The sweep ends only on its last step.
    a_clr_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR && !i_sts.clr_last) |=> (r_state == S_CLR))
        else $error("clearing sweep left early");

    // Taking an item starts an operation; it is taken only when no result is pending.
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state != S_IDLE && r_state != S_DONE))
        else $error("item load did not start an operation");

endmodule

@@ rtl/cst_dp.sv @@
// Datapath of the connection slot table: slot memories, insertion-order links,
// free-slot stack, bookkeeping registers and the result register.
// Depends on cst_pkg.
module cst_dp import cst_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [SOCK_W-1:0] i_sock_id,
    input  logic [PORT_W-1:0] i_port_num,
    input  logic              i_by_port,
    input  logic [SLOT_W-1:0] i_slot_in,
    input  logic              i_out_stall,
    output t_sts              o_sts,
    output logic              o_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [SLOT_W-1:0] o_slot_out,
    output logic [SOCK_W-1:0] o_sock_out,
    output logic [PORT_W-1:0] o_port_out,
    output logic [SLOT_W-1:0] o_entry_count
);

    localparam int DATA_W = SOCK_W + PORT_W;

    logic              m_valid [MAX_ENTRIES];
    logic [DATA_W-1:0] m_data  [MAX_ENTRIES];
    logic [SLOT_W-1:0] m_next  [MAX_ENTRIES];
    logic [SLOT_W-1:0] m_prev  [MAX_ENTRIES];
    logic [SLOT_W-1:0] m_stack [MAX_ENTRIES];

    // Item and bookkeeping registers.
    logic [MODE_W-1:0] r_mode;
    logic [SOCK_W-1:0] r_sock;
    logic [PORT_W-1:0] r_port;
    logic              r_byp;
    logic [SLOT_W-1:0] r_sin;
    logic [SLOT_W-1:0] r_first, r_last, r_count, r_depth, r_cur, r_guard, r_slot;
    logic [IDX_W-1:0]  r_clr_idx;

    // Pending result and output register.
    logic [STAT_W-1:0] r_pst;
    logic [SLOT_W-1:0] r_pslot, r_pcnt;
    logic [SOCK_W-1:0] r_psock;
    logic [PORT_W-1:0] r_pport;
    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic [SLOT_W-1:0] r_out_slot, r_out_cnt;
    logic [SOCK_W-1:0] r_out_sock;
    logic [PORT_W-1:0] r_out_port;

    // Registered read data.
    logic              r_valid_q;
    logic [DATA_W-1:0] r_data_q;
    logic [SLOT_W-1:0] r_next_q, r_prev_q, r_stack_q;

    logic [SOCK_W-1:0] q_sock;
    logic [PORT_W-1:0] q_port;
    logic [SLOT_W-1:0] new_slot, cnt_dec;
    logic [IDX_W-1:0]  rd_idx;
    logic              rd_en;

    assign q_sock   = r_data_q[DATA_W-1:PORT_W];
    assign q_port   = r_data_q[PORT_W-1:0];
    assign new_slot = (r_depth != '0) ? r_stack_q : r_count + 1'b1;
    assign cnt_dec  = r_count - 1'b1;
    assign rd_idx   = i_cmd.sr_rd ? idx_of(r_cur) : idx_of(r_sin);
    assign rd_en    = i_cmd.rm_rd || i_cmd.sr_rd;

    // Valid bits: cleared by the sweep after reset, set on insert, cleared on remove.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            m_valid[r_clr_idx] <= 1'b0;
        end else if (i_cmd.ins_wr) begin
            m_valid[idx_of(new_slot)] <= 1'b1;
        end else if (i_cmd.rm_exec) begin
            m_valid[idx_of(r_sin)] <= 1'b0;
        end
        if (rd_en) begin
            r_valid_q <= m_valid[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_wr) begin
            m_data[idx_of(new_slot)] <= {r_sock, r_port};
        end
        if (rd_en) begin
            r_data_q <= m_data[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_wr) begin
            m_next[idx_of(new_slot)] <= '0;
        end else if (i_cmd.ins_link && r_last != '0) begin
            m_next[idx_of(r_last)] <= r_slot;
        end else if (i_cmd.rm_exec && r_prev_q != '0) begin
            m_next[idx_of(r_prev_q)] <= r_next_q;
        end
        if (rd_en) begin
            r_next_q <= m_next[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_wr) begin
            m_prev[idx_of(new_slot)] <= r_last;
        end else if (i_cmd.rm_exec && r_next_q != '0) begin
            m_prev[idx_of(r_next_q)] <= r_prev_q;
        end
        if (rd_en) begin
            r_prev_q <= m_prev[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rm_exec && cnt_dec != '0 && r_depth < MAX_SLOT) begin
            m_stack[r_depth[IDX_W-1:0]] <= r_sin;
        end
        if (i_cmd.ins_rd) begin
            r_stack_q <= m_stack[idx_of(r_depth)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_sock <= i_sock_id;
            r_port <= i_port_num;
            r_byp  <= i_by_port;
            r_sin  <= i_slot_in;
        end
        if (i_cmd.ins_wr) begin
            r_slot <= new_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first   <= '0;
            r_last    <= '0;
            r_count   <= '0;
            r_depth   <= '0;
            r_cur     <= '0;
            r_guard   <= '0;
            r_clr_idx <= '0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (i_cmd.load) begin
                r_cur   <= r_first;
                r_guard <= '0;
            end
            if (i_cmd.sr_step) begin
                r_cur   <= r_next_q;
                r_guard <= r_guard + 1'b1;
            end
            if (i_cmd.ins_wr) begin
                r_count <= r_count + 1'b1;
                if (r_depth != '0) r_depth <= r_depth - 1'b1;
            end
            if (i_cmd.ins_link) begin
                if (r_last == '0) r_first <= r_slot;
                r_last <= r_slot;
            end
            if (i_cmd.rm_exec) begin
                if (r_prev_q == '0) r_first <= r_next_q;
                if (r_next_q == '0) r_last  <= r_prev_q;
                r_count <= cnt_dec;
                if (cnt_dec == '0) begin
                    r_depth <= '0;
                end else if (r_depth < MAX_SLOT) begin
                    r_depth <= r_depth + 1'b1;
                end
            end
        end
    end

    // Pending result: set by the entry write on insert, else by the final step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_full || i_cmd.res_bad || i_cmd.res_nf) begin
            r_pst   <= i_cmd.res_full ? ST_FULL : (i_cmd.res_bad ? ST_BADSLOT : ST_NOTFOUND);
            r_pslot <= '0;
            r_psock <= '0;
            r_pport <= '0;
            r_pcnt  <= r_count;
        end else if (i_cmd.ins_wr) begin
            r_pst   <= ST_OK;
            r_pslot <= new_slot;
            r_psock <= r_sock;
            r_pport <= r_port;
            r_pcnt  <= r_count + 1'b1;
        end else if (i_cmd.res_rd || i_cmd.rm_exec) begin
            r_pst   <= ST_OK;
            r_pslot <= r_sin;
            r_psock <= q_sock;
            r_pport <= q_port;
            r_pcnt  <= i_cmd.rm_exec ? cnt_dec : r_count;
        end else if (i_cmd.res_found) begin
            r_pst   <= ST_OK;
            r_pslot <= r_cur;
            r_psock <= q_sock;
            r_pport <= q_port;
            r_pcnt  <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_pst;
            r_out_slot   <= r_pslot;
            r_out_sock   <= r_psock;
            r_out_port   <= r_pport;
            r_out_cnt    <= r_pcnt;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_slot_out    = r_out_slot;
    assign o_sock_out    = r_out_sock;
    assign o_port_out    = r_out_port;
    assign o_entry_count = r_out_cnt;

    always_comb begin
        o_sts.clr_last = (r_clr_idx == IDX_W'(MAX_ENTRIES - 1));
        o_sts.mode     = r_mode;
        o_sts.full     = (r_count >= MAX_SLOT);
        o_sts.slot_bad = (r_sin == '0) || (r_sin > MAX_SLOT);
        o_sts.valid_q  = r_valid_q;
        o_sts.match    = r_byp ? (q_port == r_port) : (q_sock == r_sock);
        o_sts.cur_end  = (r_cur == '0) || (r_guard == MAX_SLOT);
        o_sts.out_free = !r_out_valid || !i_out_stall;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_SLOT)
        else $error("entry count above capacity");

    a_remove_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rm_exec |-> (r_count != '0 && r_first != '0 && r_last != '0))
        else $error("remove from an empty insertion order");

    a_link_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_link |-> (r_slot != '0 && r_slot <= MAX_SLOT))
        else $error("new entry has no valid slot number");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sr_step |=> (r_guard != '0 && r_guard <= MAX_SLOT))
        else $error("search walk ran past capacity");

endmodule

@@ verif/tb_connection_slot_table.sv @@
`timescale 1ns / 100ps
// Testbench for connection_slot_table: directed and random operations checked
// against a behavioral copy of the slot table. Depends on cst_pkg and the RTL.
module tb_connection_slot_table;
    import cst_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [SOCK_W-1:0] sock;
        logic [PORT_W-1:0] port;
        logic [SLOT_W-1:0] count;
    } t_slot_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [MODE_W-1:0] i_mode = '0;
    logic [SOCK_W-1:0] i_sock_id = '0;
    logic [PORT_W-1:0] i_port_num = '0;
    logic              i_by_port = 1'b0;
    logic [SLOT_W-1:0] i_slot_in = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [STAT_W-1:0] o_status;
    logic [SLOT_W-1:0] o_slot_out;
    logic [SOCK_W-1:0] o_sock_out;
    logic [PORT_W-1:0] o_port_out;
    logic [SLOT_W-1:0] o_entry_count;

    connection_slot_table u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the table.
    logic              live[1:MAX_ENTRIES];
    logic [SOCK_W-1:0] live_sock[1:MAX_ENTRIES];
    logic [PORT_W-1:0] live_port[1:MAX_ENTRIES];
    int                link_next[1:MAX_ENTRIES];
    int                link_prev[1:MAX_ENTRIES];
    int                oldest, newest, used_slots;
    int                freed_slots[$];

    t_slot_result pending_results[$];
    int           error_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;

    function automatic t_slot_result table_predict(logic [MODE_W-1:0] mode,
            logic [SOCK_W-1:0] sk, logic [PORT_W-1:0] pt, logic byp,
            logic [SLOT_W-1:0] sin);
        t_slot_result r;
        int s, cur;
        r = '0;
        if (mode == MODE_INSERT) begin
            if (used_slots >= MAX_ENTRIES) begin
                r.status = ST_FULL;
            end else begin
                used_slots++;
                s = (freed_slots.size() > 0) ? freed_slots.pop_back() : used_slots;
                live[s] = 1'b1;
                live_sock[s] = sk;
                live_port[s] = pt;
                link_next[s] = 0;
                link_prev[s] = newest;
                if (newest != 0) link_next[newest] = s;
                else oldest = s;
                newest = s;
                r.status = ST_OK;
                r.slot = SLOT_W'(s);
                r.sock = sk;
                r.port = pt;
            end
        end else if (mode == MODE_REMOVE || mode == MODE_READ) begin
            if (sin < 1 || sin > MAX_ENTRIES || !live[sin]) begin
                r.status = ST_BADSLOT;
            end else begin
                s = sin;
                r.status = ST_OK;
                r.slot = sin;
                r.sock = live_sock[s];
                r.port = live_port[s];
                if (mode == MODE_REMOVE) begin
                    if (link_prev[s] != 0) link_next[link_prev[s]] = link_next[s];
                    else oldest = link_next[s];
                    if (link_next[s] != 0) link_prev[link_next[s]] = link_prev[s];
                    else newest = link_prev[s];
                    live[s] = 1'b0;
                    used_slots--;
                    if (used_slots != 0) freed_slots.push_back(s);
                    else freed_slots.delete();
                end
            end
        end else begin
            r.status = ST_NOTFOUND;
            cur = oldest;
            while (cur != 0) begin
                if (byp ? (live_port[cur] == pt) : (live_sock[cur] == sk)) begin
                    r.status = ST_OK;
                    r.slot = SLOT_W'(cur);
                    r.sock = live_sock[cur];
                    r.port = live_port[cur];
                    break;
                end
                cur = link_next[cur];
            end
        end
        r.count = SLOT_W'(used_slots);
        return r;
    endfunction

    task automatic send_item(logic [MODE_W-1:0] mode, logic [SOCK_W-1:0] sk,
            logic [PORT_W-1:0] pt, logic byp, logic [SLOT_W-1:0] sin);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_mode     <= mode;
        i_sock_id  <= sk;
        i_port_num <= pt;
        i_by_port  <= byp;
        i_slot_in  <= sin;
        pending_results.push_back(table_predict(mode, sk, pt, byp, sin));
        do @(posedge i_clk); while (o_stall);
    endtask

    // A live slot somewhere along the insertion order, or 0 on an empty table.
    function automatic int pick_live_slot();
        int cur, steps;
        cur = oldest;
        if (used_slots == 0) return 0;
        steps = $urandom_range(used_slots - 1);
        repeat (steps) cur = link_next[cur];
        return cur;
    endfunction

    // Narrow pools make duplicate keys, so searches must pick the oldest match.
    function automatic logic [SOCK_W-1:0] rand_sock();
        return ($urandom_range(1)) ? SOCK_W'($urandom) : SOCK_W'($urandom_range(7));
    endfunction

    function automatic logic [PORT_W-1:0] rand_port();
        return ($urandom_range(1)) ? PORT_W'($urandom) : PORT_W'($urandom_range(7));
    endfunction

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_slot_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: status %0d slot %0d",
                       o_status, o_slot_out);
                error_count++;
            end else begin
                e = pending_results.pop_front();
                if (o_status !== e.status) begin
                    $error("status: expected %0d, actual %0d", e.status, o_status);
                    error_count++;
                end
                if (o_slot_out !== e.slot) begin
                    $error("slot_out: expected %0d, actual %0d", e.slot, o_slot_out);
                    error_count++;
                end
                if (o_sock_out !== e.sock) begin
                    $error("sock_out: expected %0h, actual %0h", e.sock, o_sock_out);
                    error_count++;
                end
                if (o_port_out !== e.port) begin
                    $error("port_out: expected %0h, actual %0h", e.port, o_port_out);
                    error_count++;
                end
                if (o_entry_count !== e.count) begin
                    $error("entry_count: expected %0d, actual %0d", e.count,
                           o_entry_count);
                    error_count++;
                end
            end
        end
    end

    task automatic test_empty_table();
        send_item(MODE_SEARCH, '0, '0, 1'b0, '0);
        send_item(MODE_SEARCH, '1, '1, 1'b1, '1);
        send_item(MODE_READ, '1, '1, 1'b0, 11'd0);
        send_item(MODE_REMOVE, '0, '0, 1'b1, 11'd1);
        send_item(MODE_READ, '0, '0, 1'b0, 11'd1024);
        send_item(MODE_REMOVE, '0, '0, 1'b0, 11'd1025);
        send_item(MODE_READ, '0, '0, 1'b0, 11'd2047);
    endtask

    task automatic test_reuse_and_search();
        send_item(MODE_INSERT, '0, '0, 1'b0, '0);
        send_item(MODE_INSERT, '1, '1, 1'b1, '1);
        send_item(MODE_INSERT, 31'd5, 16'd80, 1'b0, '0);
        send_item(MODE_INSERT, 31'd5, 16'd80, 1'b0, '0);
        send_item(MODE_SEARCH, 31'd5, '0, 1'b0, '0);
        send_item(MODE_SEARCH, '0, 16'd80, 1'b1, '0);
        send_item(MODE_SEARCH, '1, '0, 1'b0, '0);
        send_item(MODE_SEARCH, '0, 16'd81, 1'b1, '0);
        send_item(MODE_READ, '0, '0, 1'b0, 11'd2);
        // Freed numbers come back last freed first.
        send_item(MODE_REMOVE, '0, '0, 1'b0, 11'd2);
        send_item(MODE_REMOVE, '0, '0, 1'b0, 11'd3);
        send_item(MODE_REMOVE, '0, '0, 1'b0, 11'd3);
        send_item(MODE_INSERT, 31'd9, 16'd9, 1'b0, '0);
        send_item(MODE_INSERT, 31'd10, 16'd10, 1'b0, '0);
        send_item(MODE_SEARCH, 31'd5, '0, 1'b0, '0);
        // Emptying the table drops the free list; numbering starts over.
        for (int s = 1; s <= 4; s++) send_item(MODE_REMOVE, '0, '0, 1'b0, SLOT_W'(s));
        send_item(MODE_INSERT, 31'd1, 16'd1, 1'b0, '0);
        send_item(MODE_REMOVE, '0, '0, 1'b0, 11'd1);
    endtask

    task automatic test_random_traffic(int items);
        int r, s;
        logic [SOCK_W-1:0] sk;
        logic [PORT_W-1:0] pt;
        for (int n = 0; n < items; n++) begin
            r = $urandom_range(99);
            if (used_slots < 4 && r < 60) r = 0;
            if (used_slots >= 48 && r < 35) r = 40;
            if (r < 35) begin
                send_item(MODE_INSERT, rand_sock(), rand_port(), 1'($urandom),
                          SLOT_W'($urandom));
            end else if (r < 60) begin
                s = pick_live_slot();
                send_item(MODE_REMOVE, SOCK_W'($urandom), PORT_W'($urandom),
                          1'($urandom), SLOT_W'(s));
            end else if (r < 80) begin
                s = pick_live_slot();
                sk = (s != 0 && $urandom_range(9) < 7) ? live_sock[s] : rand_sock();
                pt = (s != 0 && $urandom_range(9) < 7) ? live_port[s] : rand_port();
                send_item(MODE_SEARCH, sk, pt, 1'($urandom), SLOT_W'($urandom));
            end else if (r < 93) begin
                s = pick_live_slot();
                send_item(MODE_READ, SOCK_W'($urandom), PORT_W'($urandom),
                          1'($urandom), SLOT_W'(s));
            end else begin
                // Arbitrary slot numbers, including out of range and empty ones.
                send_item($urandom_range(1) ? MODE_READ : MODE_REMOVE,
                          SOCK_W'($urandom), PORT_W'($urandom), 1'($urandom),
                          SLOT_W'($urandom));
            end
        end
    endtask

    initial begin
        for (int s = 1; s <= MAX_ENTRIES; s++) live[s] = 1'b0;
        oldest = 0;
        newest = 0;
        used_slots = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_table();
        test_reuse_and_search();
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random_traffic(138);
        send_idle_pct = 53; recv_stall_pct = 0;  test_random_traffic(138);
        send_idle_pct = 0;  recv_stall_pct = 53; test_random_traffic(138);
        send_idle_pct = 27; recv_stall_pct = 27; test_random_traffic(138);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
